// ===== src/fw2d_pkg.sv =====
// Shared types, codes and the control program of the 2-D Fenwick sum block.
// Used by the top level; depends on nothing else.
`default_nettype none

package fw2d_pkg;

  // Fixed field widths of the transaction ports.
  localparam int ROW_W   = 8;
  localparam int COL_W   = 9;
  localparam int SUM_W   = 48;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST = 8'd128;
  localparam logic [COL_W-1:0] COL_COUNT_RST = 9'd256;

  // Operation and status codes.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERR   = 1'b1;

  // Datapath actions of one control word.
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RD_CELL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELTA   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UP_RD   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UP_WR   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_Q_WALK  = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RESULT  = 3'd7;

  // Sequencing conditions.
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] C_NEXT         = 2'd0;
  localparam logic [COND_W-1:0] C_GOTO         = 2'd1;
  localparam logic [COND_W-1:0] C_UP_DONE_GOTO = 2'd2;
  localparam logic [COND_W-1:0] C_DN_WAIT      = 2'd3;

  // Program addresses.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_SET_RD    = 4'd1;
  localparam logic [UPC_W-1:0] UPC_SET_DELTA = 4'd2;
  localparam logic [UPC_W-1:0] UPC_UP_RD     = 4'd3;
  localparam logic [UPC_W-1:0] UPC_UP_WR     = 4'd4;
  localparam logic [UPC_W-1:0] UPC_SET_END   = 4'd5;
  localparam logic [UPC_W-1:0] UPC_Q_LD0     = 4'd6;
  localparam logic [UPC_W-1:0] UPC_Q_WK0     = 4'd7;
  localparam logic [UPC_W-1:0] UPC_Q_LD1     = 4'd8;
  localparam logic [UPC_W-1:0] UPC_Q_WK1     = 4'd9;
  localparam logic [UPC_W-1:0] UPC_Q_LD2     = 4'd10;
  localparam logic [UPC_W-1:0] UPC_Q_WK2     = 4'd11;
  localparam logic [UPC_W-1:0] UPC_Q_LD3     = 4'd12;
  localparam logic [UPC_W-1:0] UPC_Q_WK3     = 4'd13;
  localparam logic [UPC_W-1:0] UPC_Q_RES     = 4'd14;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [1:0]        corner;
    logic [UPC_W-1:0]  target;
    logic              fin;
  } ctl_t;

  // Query corners: 0 (last,last) add, 1 (last,first-1) sub,
  // 2 (first-1,last) sub, 3 (first-1,first-1) add.
  function automatic ctl_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctl_t w;
    w = '{ACT_NONE, C_NEXT, 2'd0, UPC_SET_END, 1'b1};
    case (upc)
      UPC_SET_RD:    w = '{ACT_RD_CELL, C_NEXT, 2'd0, UPC_SET_END, 1'b0};
      UPC_SET_DELTA: w = '{ACT_DELTA, C_NEXT, 2'd0, UPC_SET_END, 1'b0};
      UPC_UP_RD:     w = '{ACT_UP_RD, C_UP_DONE_GOTO, 2'd0, UPC_SET_END, 1'b0};
      UPC_UP_WR:     w = '{ACT_UP_WR, C_GOTO, 2'd0, UPC_UP_RD, 1'b0};
      UPC_SET_END:   w = '{ACT_NONE, C_NEXT, 2'd0, UPC_SET_END, 1'b1};
      UPC_Q_LD0:     w = '{ACT_LOAD, C_NEXT, 2'd0, UPC_SET_END, 1'b0};
      UPC_Q_WK0:     w = '{ACT_Q_WALK, C_DN_WAIT, 2'd0, UPC_SET_END, 1'b0};
      UPC_Q_LD1:     w = '{ACT_LOAD, C_NEXT, 2'd1, UPC_SET_END, 1'b0};
      UPC_Q_WK1:     w = '{ACT_Q_WALK, C_DN_WAIT, 2'd0, UPC_SET_END, 1'b0};
      UPC_Q_LD2:     w = '{ACT_LOAD, C_NEXT, 2'd2, UPC_SET_END, 1'b0};
      UPC_Q_WK2:     w = '{ACT_Q_WALK, C_DN_WAIT, 2'd0, UPC_SET_END, 1'b0};
      UPC_Q_LD3:     w = '{ACT_LOAD, C_NEXT, 2'd3, UPC_SET_END, 1'b0};
      UPC_Q_WK3:     w = '{ACT_Q_WALK, C_DN_WAIT, 2'd0, UPC_SET_END, 1'b0};
      UPC_Q_RES:     w = '{ACT_RESULT, C_NEXT, 2'd0, UPC_SET_END, 1'b1};
      default:       w = '{ACT_NONE, C_NEXT, 2'd0, UPC_SET_END, 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/fenwick_2d_point_set_rect_sum.sv =====
// Top level of the 2-D Fenwick tree block: microcoded sequencer and datapath.
// Depends on fw2d_pkg and fw2d_ram.
`default_nettype none

// Usage.
// A command transaction is accepted at a rising edge with start high and busy
// low. opcode 0 replaces one cell value and gives no result; opcode 1 returns
// the sum over the inclusive rectangle first_row..last_row by
// first_col..last_col. Each result is shown on out_rect_sum and out_status for
// exactly one cycle with out_valid high; the receiver cannot stall, so no
// result waits. Bad coordinates on a query give status 1 and a zero sum in the
// cycle after acceptance; a bad set is dropped at once.
// A set keeps busy high through its update walk of N tree nodes, N at most
// (log2(MAX_ROWS)+1)*(log2(MAX_COLS)+1), 72 at the default size. A query
// keeps busy high through four prefix walks, one per corner, of at most
// log2(MAX_ROWS)*log2(MAX_COLS) nodes each, 56 at the default size, and ends
// with the result strobe. The tree memory has a single read port: one node
// read per cycle on a query, a read-modify-write per node on a set.
// The cfg channel is always ready; row_count and col_count only govern the
// range checks, and the user must write them only while the block is idle;
// the block itself does not enforce this. After reset busy stays high while
// a clearing pass zeroes all 2**(RB+CB) entries (32768 by default) of both
// memories, one entry a cycle.
module fenwick_2d_point_set_rect_sum
  import fw2d_pkg::*;
#(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_opcode,
  input  wire logic [ROW_W-1:0]            in_first_row,
  input  wire logic [COL_W-1:0]            in_first_col,
  input  wire logic [ROW_W-1:0]            in_last_row,
  input  wire logic [COL_W-1:0]            in_last_col,
  input  wire logic signed [VALUE_BITS-1:0] in_new_value,
  output logic                             out_valid,
  output logic signed [SUM_W-1:0]          out_rect_sum,
  output logic                             out_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [COL_W-1:0]            cfg_data
);

  // Address bits per dimension; the memory is addressed by {row-1, col-1}.
  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RB + CB;
  // Walk index width: holds a coordinate and an update step past the grid edge.
  localparam int MAXRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IWB   = $clog2(MAXRC + 1) + 1;
  localparam int IW    = (IWB > COL_W) ? IWB : COL_W;

  function automatic logic [IW-1:0] low_bit(input logic [IW-1:0] v);
    return v & (~v + IW'(1));
  endfunction

  function automatic logic [AW-1:0] grid_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    logic [IW-1:0] rm;
    logic [IW-1:0] cm;
    rm = r - IW'(1);
    cm = c - IW'(1);
    return {rm[RB-1:0], cm[CB-1:0]};
  endfunction

  // Control state.
  logic             clr_r, clr_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             run_r, run_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_count_r, col_count_nxt;

  // Datapath registers.
  logic [IW-1:0]            r1_r, r1_nxt, c1_r, c1_nxt;
  logic [IW-1:0]            r2_r, r2_nxt, c2_r, c2_nxt;
  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [IW-1:0]            i_r, i_nxt, j_r, j_nxt, col0_r, col0_nxt;
  logic                     neg_r, neg_nxt, pend_neg_r, pend_neg_nxt;
  logic [SUM_W-1:0]         delta_r, delta_nxt, acc_r, acc_nxt;
  logic [SUM_W-1:0]         out_sum_r, out_sum_nxt;
  logic                     out_status_r, out_status_nxt;

  // Memory ports.
  logic                  tree_we, cell_we;
  logic [AW-1:0]         tree_waddr, cell_waddr;
  logic [SUM_W-1:0]      tree_wdata, tree_rdata;
  logic [VALUE_BITS-1:0] cell_wdata, cell_rdata;

  ctl_t          ctl;
  logic          accept;
  logic [IW-1:0] nr, nc, ir, ic, lr, lc;
  logic          set_ok, query_ok;
  logic          up_done, dn_done;
  logic [IW-1:0] j_inc, j_dec;
  logic [IW-1:0] ld_row, ld_col;

  assign busy         = clr_r | run_r;
  assign accept       = start & ~busy;
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_rect_sum = out_sum_r;
  assign out_status   = out_status_r;

  assign ctl = ucode_rom(upc_r);

  // Counts above the grid act as the grid size.
  assign nr = (IW'(row_count_r) > IW'(MAX_ROWS)) ? IW'(MAX_ROWS) : IW'(row_count_r);
  assign nc = (IW'(col_count_r) > IW'(MAX_COLS)) ? IW'(MAX_COLS) : IW'(col_count_r);
  assign ir = IW'(in_first_row);
  assign ic = IW'(in_first_col);
  assign lr = IW'(in_last_row);
  assign lc = IW'(in_last_col);

  assign set_ok   = (ir != '0) && (ir <= nr) && (ic != '0) && (ic <= nc);
  assign query_ok = (ir != '0) && (ic != '0) && (lr <= nr) && (lc <= nc) &&
                    (ir <= lr) && (ic <= lc);

  // An update walk ends once the row index leaves the grid; a prefix walk
  // ends when either index has reached zero.
  assign up_done = i_r > IW'(MAX_ROWS);
  assign dn_done = (i_r == '0) || (j_r == '0);
  assign j_inc   = j_r + low_bit(j_r);
  assign j_dec   = j_r - low_bit(j_r);
  assign ld_row  = ctl.corner[1] ? (r1_r - IW'(1)) : r2_r;
  assign ld_col  = ctl.corner[0] ? (c1_r - IW'(1)) : c2_r;

  always_comb begin
    clr_nxt        = clr_r;
    clr_cnt_nxt    = clr_cnt_r;
    run_nxt        = run_r;
    upc_nxt        = upc_r;
    pend_nxt       = 1'b0;
    pend_neg_nxt   = pend_neg_r;
    out_valid_nxt  = 1'b0;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    r1_nxt         = r1_r;
    c1_nxt         = c1_r;
    r2_nxt         = r2_r;
    c2_nxt         = c2_r;
    val_nxt        = val_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    col0_nxt       = col0_r;
    neg_nxt        = neg_r;
    delta_nxt      = delta_r;
    acc_nxt        = acc_r;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;
    tree_we        = 1'b0;
    tree_waddr     = grid_addr(i_r, j_r);
    tree_wdata     = tree_rdata + delta_r;
    cell_we        = 1'b0;
    cell_waddr     = grid_addr(r1_r, c1_r);
    cell_wdata     = val_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_COUNT: row_count_nxt = cfg_data[ROW_W-1:0];
        REG_COL_COUNT: col_count_nxt = cfg_data;
        default: ;
      endcase
    end

    // Clearing pass after reset.
    if (clr_r) begin
      tree_we     = 1'b1;
      tree_waddr  = clr_cnt_r;
      tree_wdata  = '0;
      cell_we     = 1'b1;
      cell_waddr  = clr_cnt_r;
      cell_wdata  = '0;
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == '1) begin
        clr_nxt = 1'b0;
      end
    end

    // A tree read issued last cycle is folded into the sum now.
    if (pend_r) begin
      acc_nxt = pend_neg_r ? (acc_r - tree_rdata) : (acc_r + tree_rdata);
    end

    if (accept) begin
      r1_nxt  = ir;
      c1_nxt  = ic;
      r2_nxt  = lr;
      c2_nxt  = lc;
      val_nxt = in_new_value;
      acc_nxt = '0;
      if (in_opcode == OP_SET) begin
        if (set_ok) begin
          run_nxt = 1'b1;
          upc_nxt = UPC_SET_RD;
        end
      end else if (query_ok) begin
        run_nxt = 1'b1;
        upc_nxt = UPC_Q_LD0;
      end else begin
        out_valid_nxt  = 1'b1;
        out_sum_nxt    = '0;
        out_status_nxt = ST_ERR;
      end
    end

    if (run_r) begin
      case (ctl.act)
        ACT_RD_CELL: ;  // cell read address is always the latched cell
        ACT_DELTA: begin
          delta_nxt = SUM_W'($signed(val_r)) - SUM_W'($signed(cell_rdata));
          cell_we   = 1'b1;
          i_nxt     = r1_r;
          j_nxt     = c1_r;
          col0_nxt  = c1_r;
        end
        ACT_UP_RD: ;  // tree read address follows the walk indexes
        ACT_UP_WR: begin
          tree_we = 1'b1;
          if (j_inc > IW'(MAX_COLS)) begin
            j_nxt = col0_r;
            i_nxt = i_r + low_bit(i_r);
          end else begin
            j_nxt = j_inc;
          end
        end
        ACT_LOAD: begin
          i_nxt    = ld_row;
          j_nxt    = ld_col;
          col0_nxt = ld_col;
          neg_nxt  = ctl.corner[0] ^ ctl.corner[1];
        end
        ACT_Q_WALK: begin
          if (!dn_done) begin
            pend_nxt     = 1'b1;
            pend_neg_nxt = neg_r;
            if (j_dec == '0) begin
              j_nxt = col0_r;
              i_nxt = i_r - low_bit(i_r);
            end else begin
              j_nxt = j_dec;
            end
          end
        end
        ACT_RESULT: begin
          out_valid_nxt  = 1'b1;
          out_sum_nxt    = acc_r;
          out_status_nxt = ST_OK;
        end
        default: ;
      endcase

      case (ctl.cond)
        C_NEXT:         upc_nxt = upc_r + UPC_W'(1);
        C_GOTO:         upc_nxt = ctl.target;
        C_UP_DONE_GOTO: upc_nxt = up_done ? ctl.target : (upc_r + UPC_W'(1));
        C_DN_WAIT:      upc_nxt = dn_done ? (upc_r + UPC_W'(1)) : upc_r;
        default:        upc_nxt = upc_r + UPC_W'(1);
      endcase

      if (ctl.fin) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      run_r       <= 1'b0;
      upc_r       <= UPC_SET_END;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      row_count_r <= ROW_COUNT_RST;
      col_count_r <= COL_COUNT_RST;
    end else begin
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      run_r       <= run_nxt;
      upc_r       <= upc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r1_r         <= r1_nxt;
    c1_r         <= c1_nxt;
    r2_r         <= r2_nxt;
    c2_r         <= c2_nxt;
    val_r        <= val_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    col0_r       <= col0_nxt;
    neg_r        <= neg_nxt;
    pend_neg_r   <= pend_neg_nxt;
    delta_r      <= delta_nxt;
    acc_r        <= acc_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

  // Fenwick partial sums.
  fw2d_ram #(
    .WIDTH (SUM_W),
    .AW    (AW)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (tree_we),
    .wr_addr (tree_waddr),
    .wr_data (tree_wdata),
    .rd_addr (grid_addr(i_r, j_r)),
    .rd_data (tree_rdata)
  );

  // Current cell values, needed to form the difference on a set.
  fw2d_ram #(
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_addr (grid_addr(r1_r, c1_r)),
    .rd_data (cell_rdata)
  );

endmodule

`default_nettype wire

// ===== src/fw2d_ram.sv =====
// Generic single-clock RAM: one write port and one registered read port.
// No dependencies.
`default_nettype none

module fw2d_ram #(
  parameter int WIDTH = 48,
  parameter int AW    = 15
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== dv/fw2d_rect_sum_checker.sv =====
// Checker for the 2-D Fenwick rectangle-sum block: watches the command, result
// and configuration channels, predicts each query result and compares it.
// Depends on fw2d_pkg for field widths, opcodes, status codes and register indexes.
module fw2d_rect_sum_checker
  import fw2d_pkg::*;
#(
  parameter int GRID_ROWS = 128,
  parameter int GRID_COLS = 256,
  parameter int VALUE_W   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_opcode,
  input  logic [ROW_W-1:0]           in_first_row,
  input  logic [COL_W-1:0]           in_first_col,
  input  logic [ROW_W-1:0]           in_last_row,
  input  logic [COL_W-1:0]           in_last_col,
  input  logic signed [VALUE_W-1:0]  in_new_value,
  input  logic                       out_valid,
  input  logic signed [SUM_W-1:0]    out_rect_sum,
  input  logic                       out_status,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COL_W-1:0]           cfg_data,
  output int                         fail_count,
  output int                         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             status;
  } rect_result_t;

  logic [SUM_W-1:0]   tree_sums [0:GRID_ROWS][0:GRID_COLS];
  logic [VALUE_W-1:0] cell_vals [0:GRID_ROWS][0:GRID_COLS];
  logic [ROW_W-1:0]   row_limit;
  logic [COL_W-1:0]   col_limit;
  rect_result_t       sums_due [$];
  int                 mismatches;

  assign fail_count = mismatches;

  initial begin
    for (int i = 0; i <= GRID_ROWS; i++)
      for (int j = 0; j <= GRID_COLS; j++) begin
        tree_sums[i][j] = '0;
        cell_vals[i][j] = '0;
      end
    row_limit     = ROW_COUNT_RST;
    col_limit     = COL_COUNT_RST;
    mismatches    = 0;
    pending_count = 0;
  end

  // Prefix sum over rows 1..r and columns 1..c, modulo 2^48.
  function automatic logic [SUM_W-1:0] corner_sum(int r, int c);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = r; i > 0; i = i - (i & -i))
      for (int j = c; j > 0; j = j - (j & -j))
        acc = acc + tree_sums[i][j];
    return acc;
  endfunction

  // Update walks always cover the whole grid, whatever the configured counts.
  task automatic bump_tree(int r, int c, logic [SUM_W-1:0] delta);
    for (int i = r; i <= GRID_ROWS; i = i + (i & -i))
      for (int j = c; j <= GRID_COLS; j = j + (j & -j))
        tree_sums[i][j] = tree_sums[i][j] + delta;
  endtask

  task automatic take_cmd(logic op, int r1, int c1, int r2, int c2,
                          logic [VALUE_W-1:0] v);
    int           rows_eff;
    int           cols_eff;
    logic [SUM_W-1:0] wide_new;
    logic [SUM_W-1:0] wide_old;
    rect_result_t res;
    rows_eff = (row_limit > GRID_ROWS) ? GRID_ROWS : int'(row_limit);
    cols_eff = (col_limit > GRID_COLS) ? GRID_COLS : int'(col_limit);
    if (op == OP_SET) begin
      // Out-of-range cells are dropped without touching any state.
      if (r1 >= 1 && r1 <= rows_eff && c1 >= 1 && c1 <= cols_eff) begin
        wide_new = {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
        wide_old = {{(SUM_W-VALUE_W){cell_vals[r1][c1][VALUE_W-1]}}, cell_vals[r1][c1]};
        bump_tree(r1, c1, wide_new - wide_old);
        cell_vals[r1][c1] = v;
      end
    end else begin
      if (r1 < 1 || c1 < 1 || r2 > rows_eff || c2 > cols_eff || r1 > r2 || c1 > c2) begin
        res.sum    = '0;
        res.status = ST_ERR;
      end else begin
        res.sum = corner_sum(r2, c2) - corner_sum(r2, c1 - 1)
                - corner_sum(r1 - 1, c2) + corner_sum(r1 - 1, c1 - 1);
        res.status = ST_OK;
      end
      sums_due.push_back(res);
    end
  endtask

  always @(posedge clk) begin : watch
    rect_result_t want;
    if (rst_n === 1'b1) begin
      if (out_valid !== 1'b0) begin
        if (sums_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with no query pending: expected none, got rect_sum %0d status %0b",
                   $time, out_rect_sum, out_status);
        end else begin
          want = sums_due.pop_front();
          if (out_rect_sum !== want.sum) begin
            mismatches++;
            $display("%0t: rect_sum mismatch: expected %0d, got %0d",
                     $time, $signed(want.sum), out_rect_sum);
          end
          if (out_status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0b, got %0b",
                     $time, want.status, out_status);
          end
        end
      end
      // A command accepted at this edge still sees the counts from before it.
      if (start && !busy)
        take_cmd(in_opcode, int'(in_first_row), int'(in_first_col),
                 int'(in_last_row), int'(in_last_col), in_new_value);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_COUNT: row_limit = cfg_data[ROW_W-1:0];
          REG_COL_COUNT: col_limit = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count <= sums_due.size();
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for fenwick_2d_point_set_rect_sum: clock, reset, command and
// register stimulus, and the final verdict. Depends on fw2d_pkg and the checker.
module tb
  import fw2d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS = 128;
  localparam int GRID_COLS = 256;
  localparam int VALUE_W   = 32;
  // An index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  // A set gives no result, so before a register write we let its longest
  // update walk run out.
  localparam int SET_TAIL = 160;
  // At the end, room for the slowest query on top of everything else.
  localparam int END_TAIL = 320;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      in_opcode = OP_SET;
  logic [ROW_W-1:0]          in_first_row = '0;
  logic [COL_W-1:0]          in_first_col = '0;
  logic [ROW_W-1:0]          in_last_row = '0;
  logic [COL_W-1:0]          in_last_col = '0;
  logic signed [VALUE_W-1:0] in_new_value = '0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = REG_ROW_COUNT;
  logic [COL_W-1:0]          cfg_data = '0;
  wire                       busy;
  wire                       out_valid;
  wire signed [SUM_W-1:0]    out_rect_sum;
  wire                       out_status;
  wire                       cfg_ready;
  int                        fail_count;
  int                        pending_count;

  // Sender gaps are on unless switched off for the final stretch.
  bit idle_on = 1'b1;
  // Effective grid size as the block sees it, used only to aim the stimulus.
  int rows_live = GRID_ROWS;
  int cols_live = GRID_COLS;

  always #1 clk = ~clk;

  fenwick_2d_point_set_rect_sum #(
    .MAX_ROWS  (GRID_ROWS),
    .MAX_COLS  (GRID_COLS),
    .VALUE_BITS(VALUE_W)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_opcode   (in_opcode),
    .in_first_row(in_first_row),
    .in_first_col(in_first_col),
    .in_last_row (in_last_row),
    .in_last_col (in_last_col),
    .in_new_value(in_new_value),
    .out_valid   (out_valid),
    .out_rect_sum(out_rect_sum),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  fw2d_rect_sum_checker #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS),
    .VALUE_W  (VALUE_W)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_first_row (in_first_row),
    .in_first_col (in_first_col),
    .in_last_row  (in_last_row),
    .in_last_col  (in_last_col),
    .in_new_value (in_new_value),
    .out_valid    (out_valid),
    .out_rect_sum (out_rect_sum),
    .out_status   (out_status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Presents one command transaction and returns at the edge that accepts it.
  // Start is left high so that back-to-back commands need no extra cycle.
  task automatic send_cmd(logic op, int r1, int c1, int r2, int c2,
                          logic [VALUE_W-1:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start        <= 1'b1;
    in_opcode    <= op;
    in_first_row <= ROW_W'(r1);
    in_first_col <= COL_W'(c1);
    in_last_row  <= ROW_W'(r2);
    in_last_col  <= COL_W'(c2);
    in_new_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COL_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Counts above the grid act as the grid size; zero rules out every cell.
  task automatic program_grid(int rows, int cols, bit poke_spare);
    cfg_write(REG_ROW_COUNT, rows);
    cfg_write(REG_COL_COUNT, cols);
    if (poke_spare)
      cfg_write(REG_SPARE, $urandom_range(0, 511));
    cfg_valid <= 1'b0;
    rows_live = (rows > GRID_ROWS) ? GRID_ROWS : rows;
    cols_live = (cols > GRID_COLS) ? GRID_COLS : cols;
  endtask

  // Holds the sender until every query result is back and the block is idle.
  task automatic drain(int tail);
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Most coordinates fall inside the grid, many in a small corner so that
  // cells get overwritten, and a few anywhere in the field to hit range errors.
  function automatic int pick_coord(int limit, int field_max);
    int roll;
    roll = $urandom_range(0, 19);
    if (limit == 0 || roll == 0)
      return $urandom_range(0, field_max);
    if (roll < 8)
      return $urandom_range(1, (limit < 6) ? limit : 6);
    if (roll == 8)
      return limit;
    return $urandom_range(1, limit);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 64)) - 32'd32;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    logic op;
    int   r1;
    int   c1;
    int   r2;
    int   c2;
    int   t;
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(0, 1) == 0) ? OP_SET : OP_QUERY;
      r1 = pick_coord(rows_live, 255);
      c1 = pick_coord(cols_live, 511);
      r2 = pick_coord(rows_live, 255);
      c2 = pick_coord(cols_live, 511);
      // Mostly proper rectangles; now and then a reversed one is kept.
      if ($urandom_range(0, 11) != 0) begin
        if (r1 > r2) begin
          t = r1; r1 = r2; r2 = t;
        end
        if (c1 > c2) begin
          t = c1; c1 = c2; c2 = t;
        end
      end
      if (op == OP_QUERY && $urandom_range(0, 15) == 0) begin
        r1 = 1;
        c1 = 1;
        r2 = rows_live;
        c2 = cols_live;
      end
      send_cmd(op, r1, c1, r2, c2, pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset grid size. The first command also waits out
    // the clearing pass, since busy stays high until the memories are zero.
    send_cmd(OP_QUERY, 1, 1, 128, 256, 0);
    send_cmd(OP_SET, 1, 1, 0, 0, 32'h7FFF_FFFF);
    send_cmd(OP_SET, 128, 256, 255, 511, 32'h8000_0000);
    send_cmd(OP_SET, 1, 256, 0, 0, 32'hFFFF_FFFF);
    send_cmd(OP_SET, 128, 1, 0, 0, 32'd1);
    // Rewriting a cell must add only the difference to the tree.
    send_cmd(OP_SET, 1, 1, 0, 0, 32'd5);
    // Sets outside the grid are dropped.
    send_cmd(OP_SET, 0, 5, 0, 0, 32'd99);
    send_cmd(OP_SET, 5, 0, 0, 0, 32'd99);
    send_cmd(OP_SET, 129, 5, 0, 0, 32'd99);
    send_cmd(OP_SET, 3, 257, 0, 0, 32'd99);
    send_cmd(OP_SET, 255, 511, 0, 0, 32'd99);
    send_cmd(OP_QUERY, 1, 1, 128, 256, 0);
    send_cmd(OP_QUERY, 128, 256, 128, 256, 0);
    send_cmd(OP_QUERY, 1, 1, 1, 1, 0);
    send_cmd(OP_QUERY, 1, 1, 1, 256, 0);
    send_cmd(OP_QUERY, 128, 1, 128, 256, 0);
    send_cmd(OP_QUERY, 2, 2, 127, 255, 0);
    // Reversed rectangles and coordinates outside the grid give an error.
    send_cmd(OP_QUERY, 5, 1, 4, 256, 0);
    send_cmd(OP_QUERY, 1, 10, 128, 9, 0);
    send_cmd(OP_QUERY, 0, 1, 128, 256, 0);
    send_cmd(OP_QUERY, 1, 0, 128, 256, 0);
    send_cmd(OP_QUERY, 1, 1, 129, 256, 0);
    send_cmd(OP_QUERY, 1, 1, 128, 257, 0);
    send_cmd(OP_QUERY, 255, 511, 255, 511, 0);

    send_random(400);

    // Smallest grid: one cell.
    drain(SET_TAIL);
    program_grid(1, 1, 1'b0);
    send_random(60);

    // Zero counts: every coordinate is out of range. The unused index is hit too.
    drain(SET_TAIL);
    program_grid(0, 0, 1'b1);
    send_random(30);

    // Counts above the grid act as the full grid; the tree kept its contents.
    drain(SET_TAIL);
    program_grid(255, 511, 1'b0);
    send_random(200);

    drain(SET_TAIL);
    program_grid($urandom_range(1, GRID_ROWS), $urandom_range(1, GRID_COLS), 1'b0);
    send_random(150);
    idle_on = 1'b0;
    send_random(150);

    drain(END_TAIL);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: several times the slowest legal run, clearing pass included.
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== fenwick_2d_point_set_rect_sum.f =====
src/fw2d_pkg.sv
src/fw2d_ram.sv
src/fenwick_2d_point_set_rect_sum.sv
dv/fw2d_rect_sum_checker.sv
dv/tb.sv
